@@ hdl/deq_pkg.sv @@
// Shared sizes, codes, command and status types for the double-ended queue.
package deq_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic signed [31:0] word_t;

	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_BACK   = 3'd3;
	localparam logic [2:0] KIND_DUMP       = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_READ_FIRST,
		OP_READ_NEXT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       load;
		logic [1:0] res_status;
		logic       res_last;
		logic       res_data;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic first_is_last;
		logic next_is_last;
	} stat_t;

	function automatic idx_t slot(idx_t base, cnt_t offset);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, offset};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

@@ hdl/double_ended_queue.sv @@
// Top level of the double-ended queue: controller and datapath.
//
// A command transfers at a rising edge where start is high and busy is low. Its result
// appears on status, data and last with strobe high for exactly one cycle, in the cycle
// after the transfer; the receiver cannot stall, so it must take every result as it
// comes. Push and pop keep busy low, so a command may follow in every cycle; the data
// comes from the registered read port of the ring store. A dump of N elements returns
// N results on consecutive cycles, one store read each, and holds busy high until the
// store read of its last element is issued. A dump of an empty queue, or any failed
// push or pop, returns a single result with last set. Kinds five to seven are ignored
// and give no result.
module double_ended_queue import deq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  word_t       value,
	output logic        strobe,
	output logic [1:0]  status,
	output word_t       data,
	output logic        last
);

	cmd_t  cmd;
	stat_t stat;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.busy   (busy),
		.strobe (strobe),
		.cmd    (cmd)
	);

	deq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (value),
		.stat   (stat),
		.status (status),
		.data   (data),
		.last   (last)
	);

endmodule

@@ hdl/deq_dp.sv @@
// Datapath of the double-ended queue: ring store, indices, count and result registers.
module deq_dp import deq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  word_t      value,
	output stat_t      stat,
	output logic [1:0] status,
	output word_t      data,
	output logic       last
);

	word_t      mem_q [DEPTH];
	word_t      rd_q;
	idx_t       front_q;
	cnt_t       count_q;
	cnt_t       off_q;
	logic [1:0] status_q;
	logic       last_q;
	logic       sel_q;

	idx_t addr;
	idx_t front_dec;
	logic we;
	logic re;

	assign front_dec = (front_q == '0) ? idx_t'(DEPTH - 1) : front_q - idx_t'(1);

	assign stat.full          = (count_q == cnt_t'(DEPTH));
	assign stat.empty         = (count_q == '0);
	assign stat.first_is_last = (count_q == cnt_t'(1));
	assign stat.next_is_last  = (off_q == count_q - cnt_t'(1));

	always_comb begin
		addr = front_q;
		we   = 1'b0;
		re   = 1'b0;
		case (cmd.op)
			OP_PUSH_FRONT: begin
				addr = front_dec;
				we   = 1'b1;
			end
			OP_PUSH_BACK: begin
				addr = slot(front_q, count_q);
				we   = 1'b1;
			end
			OP_POP_FRONT: begin
				addr = front_q;
				re   = 1'b1;
			end
			OP_POP_BACK: begin
				addr = slot(front_q, count_q - cnt_t'(1));
				re   = 1'b1;
			end
			OP_READ_FIRST: begin
				addr = front_q;
				re   = 1'b1;
			end
			OP_READ_NEXT: begin
				addr = slot(front_q, off_q);
				re   = 1'b1;
			end
			default: begin
				addr = front_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= value;
		end
		if (re) begin
			rd_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			off_q    <= '0;
			status_q <= ST_OK;
			last_q   <= 1'b0;
			sel_q    <= 1'b0;
		end else begin
			case (cmd.op)
				OP_PUSH_FRONT: begin
					front_q <= front_dec;
					count_q <= count_q + cnt_t'(1);
				end
				OP_PUSH_BACK: begin
					count_q <= count_q + cnt_t'(1);
				end
				OP_POP_FRONT: begin
					front_q <= slot(front_q, cnt_t'(1));
					count_q <= count_q - cnt_t'(1);
				end
				OP_POP_BACK: begin
					count_q <= count_q - cnt_t'(1);
				end
				OP_READ_FIRST: begin
					off_q <= cnt_t'(1);
				end
				OP_READ_NEXT: begin
					off_q <= off_q + cnt_t'(1);
				end
				default: begin
					off_q <= off_q;
				end
			endcase
			if (cmd.load) begin
				status_q <= cmd.res_status;
				last_q   <= cmd.res_last;
				sel_q    <= cmd.res_data;
			end
		end
	end

	assign status = status_q;
	assign last   = last_q;
	assign data   = sel_q ? rd_q : '0;

endmodule

@@ hdl/deq_ctrl.sv @@
// Controller state machine of the double-ended queue.
module deq_ctrl import deq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] kind,
	input  stat_t      stat,
	output logic       busy,
	output logic       strobe,
	output cmd_t       cmd
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t state_q;
	logic   strobe_q;
	logic   accept;

	assign busy   = (state_q == S_DUMP);
	assign accept = start && !busy;
	assign strobe = strobe_q;

	always_comb begin
		cmd = '{op: OP_NONE, load: 1'b0, res_status: ST_OK, res_last: 1'b0, res_data: 1'b0};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
							cmd.load     = 1'b1;
							cmd.res_last = 1'b1;
							if (stat.full) begin
								cmd.res_status = ST_FULL;
							end else begin
								cmd.op = (kind == KIND_PUSH_FRONT) ? OP_PUSH_FRONT
									: OP_PUSH_BACK;
							end
						end
						KIND_POP_FRONT, KIND_POP_BACK: begin
							cmd.load     = 1'b1;
							cmd.res_last = 1'b1;
							if (stat.empty) begin
								cmd.res_status = ST_EMPTY;
							end else begin
								cmd.op = (kind == KIND_POP_FRONT) ? OP_POP_FRONT
									: OP_POP_BACK;
								cmd.res_data = 1'b1;
							end
						end
						KIND_DUMP: begin
							cmd.load = 1'b1;
							if (stat.empty) begin
								cmd.res_status = ST_EMPTY;
								cmd.res_last   = 1'b1;
							end else begin
								cmd.op       = OP_READ_FIRST;
								cmd.res_data = 1'b1;
								cmd.res_last = stat.first_is_last;
							end
						end
						default: begin
							cmd.load = 1'b0;
						end
					endcase
				end
			end
			S_DUMP: begin
				cmd.op       = OP_READ_NEXT;
				cmd.load     = 1'b1;
				cmd.res_data = 1'b1;
				cmd.res_last = stat.next_is_last;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.load;
			case (state_q)
				S_IDLE: begin
					if (cmd.op == OP_READ_FIRST && !stat.first_is_last) begin
						state_q <= S_DUMP;
					end
				end
				S_DUMP: begin
					if (stat.next_is_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
